/* rtl/spdp_pkg.sv */
// ----------------------------------------------------------------------------
// spdp_pkg
// Shared types and constants for the sensor packet deframe parser.
// ----------------------------------------------------------------------------
package spdp_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'h9A;

   // Default per-type record lengths and parse window
   localparam int unsigned STATIC_TACTILE_COUNT_DEF  = 24;
   localparam int unsigned DYNAMIC_TACTILE_COUNT_DEF = 1;
   localparam int unsigned MAX_DATA_BYTES_DEF        = 60;

   // Fixed value counts for the motion and temperature records
   localparam logic [5:0] MOTION_COUNT = 6'd3;
   localparam logic [5:0] TEMP_COUNT   = 6'd1;

   // Frame positions of the header bytes
   localparam logic [8:0] POS_HUNT   = 9'd0;
   localparam logic [8:0] POS_LENGTH = 9'd3;
   localparam logic [8:0] HDR_BYTES  = 9'd4;

   // Header type nibble range that is understood
   localparam logic [3:0] TYPE_FIRST = 4'h1;
   localparam logic [3:0] TYPE_LAST  = 4'h6;

   typedef enum logic [2:0] {
      KIND_STATIC  = 3'd0,
      KIND_DYNAMIC = 3'd1,
      KIND_ACCEL   = 3'd2,
      KIND_GYRO    = 3'd3,
      KIND_MAGNET  = 3'd4,
      KIND_TEMP    = 3'd5
   } sensor_kind_type;

   typedef enum logic {
      RES_VALUE = 1'b0,
      RES_END   = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic        result_kind;
      logic [2:0]  sensor_kind;
      logic [1:0]  finger_index;
      logic [5:0]  value_index;
      logic [15:0] sample_value;
      logic        dynamic_seen;
      logic        last_of_run;
   } result_type;

   // Result queue depth; input is held off unless two slots are free
   localparam int unsigned RES_DEPTH = 4;

endpackage

/* rtl/sensor_packet_deframe_parser_core.sv */
// ----------------------------------------------------------------------------
// sensor_packet_deframe_parser_core
// Sync-byte framed sensor packet parser: hunts 0x9A, skips check and command
// bytes, takes the length, parses data bytes into records of 16-bit values.
// ----------------------------------------------------------------------------
// Results of an accepted byte are registered in the result queue and shown
//   on rsp_* from its head. Throughput: one byte per cycle while req_stall
//   is low; a byte that causes two results (last value and end marker) still
//   enters whole, and the queue drains one per cycle while rsp_stall is low.
// req_stall rises only while fewer than two result slots are free.
// Reset (synchronous, active high): hunting the sync byte, queue empty.
// ----------------------------------------------------------------------------
module sensor_packet_deframe_parser_core
   import spdp_pkg::*;
#(
   parameter int unsigned STATIC_TACTILE_COUNT  = STATIC_TACTILE_COUNT_DEF,
   parameter int unsigned DYNAMIC_TACTILE_COUNT = DYNAMIC_TACTILE_COUNT_DEF,
   parameter int unsigned MAX_DATA_BYTES        = MAX_DATA_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [2:0]  rsp_sensor_kind,
   output logic [1:0]  rsp_finger_index,
   output logic [5:0]  rsp_value_index,
   output logic [15:0] rsp_sample_value,
   output logic        rsp_dynamic_seen,
   output logic        rsp_last_of_run
);

   localparam int unsigned PTR_W = $clog2(RES_DEPTH);
   localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

   localparam logic [5:0] STATIC_CNT  = 6'(STATIC_TACTILE_COUNT);
   localparam logic [5:0] DYNAMIC_CNT = 6'(DYNAMIC_TACTILE_COUNT);
   localparam logic [8:0] MAX_DATA    = 9'(MAX_DATA_BYTES);

   // ---------------------------------------------------------------------
   // Framing and record state
   // ---------------------------------------------------------------------
   logic [8:0] frame_pos_ff,   frame_pos_in;
   logic [7:0] pay_len_ff,     pay_len_in;
   logic       in_record_ff,   in_record_in;
   logic [2:0] rec_kind_ff,    rec_kind_in;
   logic [1:0] rec_finger_ff,  rec_finger_in;
   logic [5:0] values_done_ff, values_done_in;
   logic       hi_held_ff,     hi_held_in;
   logic [7:0] hi_byte_ff,     hi_byte_in;
   logic       halted_ff,      halted_in;
   logic       dyn_flag_ff,    dyn_flag_in;

   // Result queue
   result_type           res_q_ff [RES_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff,  count_in;

   logic       accept;
   logic       pop;
   logic       val_emit;
   logic       end_emit;
   result_type value_res;
   result_type end_res;
   result_type slot0;
   result_type slot1;
   logic [1:0] n_push;

   // Record length for the current record kind
   function automatic logic [5:0] kind_count(input logic [2:0] kind);
      logic [5:0] cnt;
      case (kind)
         KIND_STATIC:  cnt = STATIC_CNT;
         KIND_DYNAMIC: cnt = DYNAMIC_CNT;
         KIND_ACCEL,
         KIND_GYRO,
         KIND_MAGNET:  cnt = MOTION_COUNT;
         default:      cnt = TEMP_COUNT;
      endcase
      return cnt;
   endfunction

   // Stall depends only on queue fill: two free slots cover any byte.
   assign req_stall = (count_ff > CNT_W'(RES_DEPTH - 2));
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid & ~rsp_stall;

   // ---------------------------------------------------------------------
   // Per-byte framing and parsing
   // ---------------------------------------------------------------------
   always_comb begin
      logic [8:0] pos_next;
      logic [7:0] len_v;
      logic [5:0] vd_next;

      frame_pos_in   = frame_pos_ff;
      pay_len_in     = pay_len_ff;
      in_record_in   = in_record_ff;
      rec_kind_in    = rec_kind_ff;
      rec_finger_in  = rec_finger_ff;
      values_done_in = values_done_ff;
      hi_held_in     = hi_held_ff;
      hi_byte_in     = hi_byte_ff;
      halted_in      = halted_ff;
      dyn_flag_in    = dyn_flag_ff;
      val_emit       = 1'b0;
      end_emit       = 1'b0;
      pos_next       = frame_pos_ff + 9'd1;
      len_v          = pay_len_ff;
      vd_next        = values_done_ff + 6'd1;

      value_res              = '0;
      value_res.result_kind  = RES_VALUE;
      value_res.sensor_kind  = rec_kind_ff;
      value_res.finger_index = rec_finger_ff;
      value_res.value_index  = values_done_ff;
      value_res.sample_value = {hi_byte_ff, req_in_byte};

      if (accept) begin
         if (frame_pos_ff == POS_HUNT) begin
            if (req_in_byte == SYNC_BYTE) begin
               // new packet: drop any record context
               frame_pos_in   = 9'd1;
               in_record_in   = 1'b0;
               rec_kind_in    = '0;
               rec_finger_in  = '0;
               values_done_in = '0;
               hi_held_in     = 1'b0;
               hi_byte_in     = '0;
               halted_in      = 1'b0;
               dyn_flag_in    = 1'b0;
            end
         end else if (frame_pos_ff < POS_LENGTH) begin
            // check and command bytes are passed over
            frame_pos_in = pos_next;
         end else begin
            if (frame_pos_ff == POS_LENGTH) begin
               len_v      = req_in_byte;
               pay_len_in = req_in_byte;
            end else if ((frame_pos_ff - HDR_BYTES) < MAX_DATA && !halted_ff) begin
               if (!in_record_ff) begin
                  // record header
                  if (req_in_byte[7:4] < TYPE_FIRST || req_in_byte[7:4] > TYPE_LAST) begin
                     halted_in = 1'b1;
                  end else begin
                     rec_kind_in    = 3'(req_in_byte[7:4] - TYPE_FIRST);
                     rec_finger_in  = req_in_byte[3:2];
                     values_done_in = '0;
                     hi_held_in     = 1'b0;
                     hi_byte_in     = '0;
                     in_record_in   = 1'b1;
                     if (3'(req_in_byte[7:4] - TYPE_FIRST) == KIND_DYNAMIC) begin
                        dyn_flag_in = 1'b1;
                     end
                  end
               end else if (!hi_held_ff) begin
                  hi_held_in = 1'b1;
                  hi_byte_in = req_in_byte;
               end else begin
                  // low byte completes a value
                  val_emit   = 1'b1;
                  hi_held_in = 1'b0;
                  hi_byte_in = '0;
                  if (vd_next >= kind_count(rec_kind_ff)) begin
                     in_record_in   = 1'b0;
                     values_done_in = '0;
                  end else begin
                     values_done_in = vd_next;
                  end
               end
            end

            frame_pos_in = pos_next;
            if (pos_next >= ({1'b0, len_v} + HDR_BYTES)) begin
               end_emit       = 1'b1;
               frame_pos_in   = POS_HUNT;
               in_record_in   = 1'b0;
               rec_kind_in    = '0;
               rec_finger_in  = '0;
               values_done_in = '0;
               hi_held_in     = 1'b0;
               hi_byte_in     = '0;
               halted_in      = 1'b0;
               dyn_flag_in    = 1'b0;
            end
         end
      end

      // end marker reports the flag including this byte's header
      end_res              = '0;
      end_res.result_kind  = RES_END;
      end_res.dynamic_seen = dyn_flag_in | (end_emit & dyn_flag_ff)
                             | (end_emit & accept & ~halted_ff & ~in_record_ff
                                & (frame_pos_ff > POS_LENGTH)
                                & ((frame_pos_ff - HDR_BYTES) < MAX_DATA)
                                & (req_in_byte[7:4] == 4'(KIND_DYNAMIC) + TYPE_FIRST));
   end

   // ---------------------------------------------------------------------
   // Slot assembly: value first, then end marker
   // ---------------------------------------------------------------------
   always_comb begin
      slot0 = val_emit ? value_res : end_res;
      slot1 = end_res;
      slot0.last_of_run = ~(val_emit & end_emit);
      slot1.last_of_run = 1'b1;
      n_push = {1'b0, val_emit} + {1'b0, end_emit};
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(n_push) - CNT_W'(pop);
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pos_ff   <= POS_HUNT;
         pay_len_ff     <= '0;
         in_record_ff   <= 1'b0;
         rec_kind_ff    <= '0;
         rec_finger_ff  <= '0;
         values_done_ff <= '0;
         hi_held_ff     <= 1'b0;
         hi_byte_ff     <= '0;
         halted_ff      <= 1'b0;
         dyn_flag_ff    <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         frame_pos_ff   <= frame_pos_in;
         pay_len_ff     <= pay_len_in;
         in_record_ff   <= in_record_in;
         rec_kind_ff    <= rec_kind_in;
         rec_finger_ff  <= rec_finger_in;
         values_done_ff <= values_done_in;
         hi_held_ff     <= hi_held_in;
         hi_byte_ff     <= hi_byte_in;
         halted_ff      <= halted_in;
         dyn_flag_ff    <= dyn_flag_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
   end

   // Queue payload, no reset needed
   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         res_q_ff[wr_ptr_ff] <= slot0;
      end
      if (n_push == 2'd2) begin
         res_q_ff[wr_ptr_ff + PTR_W'(1)] <= slot1;
      end
   end

   // ---------------------------------------------------------------------
   // Result ports from the queue head
   // ---------------------------------------------------------------------
   always_comb begin
      result_type head;
      head             = res_q_ff[rd_ptr_ff];
      rsp_result_kind  = head.result_kind;
      rsp_sensor_kind  = head.sensor_kind;
      rsp_finger_index = head.finger_index;
      rsp_value_index  = head.value_index;
      rsp_sample_value = head.sample_value;
      rsp_dynamic_seen = head.dynamic_seen;
      rsp_last_of_run  = head.last_of_run;
   end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the sensor packet deframe parser. An initial block
// builds a queue of bytes: a few hand-made packets first, then random
// packets, most of them well formed with random record content, and the
// rest broken packets and noise between packets. A clocked driver sends
// them with random gaps. A clocked monitor updates a local packet parser
// model on each accepted byte, queues the values and end markers that the
// byte should produce, and compares each result from the block with the
// oldest one it expects.
// ----------------------------------------------------------------------------
module tb_top
   import spdp_pkg::*;
();

   // One byte to send; wait_drain holds it back until all results are in
   typedef struct {
      logic [7:0] data;
      bit         wait_drain;
   } tx_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic [2:0]  rsp_sensor_kind;
   logic [1:0]  rsp_finger_index;
   logic [5:0]  rsp_value_index;
   logic [15:0] rsp_sample_value;
   logic        rsp_dynamic_seen;
   logic        rsp_last_of_run;

   sensor_packet_deframe_parser_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_sensor_kind  (rsp_sensor_kind),
      .rsp_finger_index (rsp_finger_index),
      .rsp_value_index  (rsp_value_index),
      .rsp_sample_value (rsp_sample_value),
      .rsp_dynamic_seen (rsp_dynamic_seen),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   tx_byte_type tx_bytes_q[$];    // bytes still to send
   logic [7:0]  payload_q[$];     // data bytes of the packet being built
   result_type  expected_q[$];    // results the parser model has produced

   int unsigned bytes_sent   = 0;
   int unsigned results_seen = 0;
   int unsigned end_markers  = 0;
   int unsigned packets_made = 0;
   int unsigned error_count  = 0;
   logic        req_taken    = 1'b0;
   result_type  want;

   // ------------------------------------------------------------------------
   // Parser model state
   // ------------------------------------------------------------------------
   logic [8:0]      frame_pos  = POS_HUNT;
   logic [7:0]      pay_len    = 8'd0;
   logic            in_rec     = 1'b0;
   sensor_kind_type rec_kind   = KIND_STATIC;
   logic [1:0]      rec_finger = 2'd0;
   logic [5:0]      vals_done  = 6'd0;
   logic [8:0]      held_high  = 9'd0;    // bit 8: high byte held
   logic            halted     = 1'b0;
   logic            dyn_flag   = 1'b0;

   function automatic int unsigned values_per_record(sensor_kind_type k);
      case (k)
         KIND_STATIC:                    return STATIC_TACTILE_COUNT_DEF;
         KIND_DYNAMIC:                   return DYNAMIC_TACTILE_COUNT_DEF;
         KIND_ACCEL, KIND_GYRO, KIND_MAGNET: return MOTION_COUNT;
         default:                        return TEMP_COUNT;
      endcase
   endfunction

   task automatic clear_packet_state();
      in_rec     = 1'b0;
      rec_kind   = KIND_STATIC;
      rec_finger = 2'd0;
      vals_done  = 6'd0;
      held_high  = 9'd0;
      halted     = 1'b0;
      dyn_flag   = 1'b0;
   endtask

   // Advance the model by one accepted byte and queue what it produces
   task automatic predict_byte(input logic [7:0] b);
      result_type batch[$];
      result_type r;
      logic [3:0] nib;
      if (frame_pos == POS_HUNT) begin
         // anything but the sync byte is dropped while hunting
         if (b == SYNC_BYTE) begin
            clear_packet_state();
            frame_pos = 9'd1;
         end
      end else if (frame_pos < POS_LENGTH) begin
         // check and command bytes pass unexamined
         frame_pos = frame_pos + 9'd1;
      end else begin
         if (frame_pos == POS_LENGTH) begin
            pay_len = b;
         end else if (frame_pos - HDR_BYTES < MAX_DATA_BYTES_DEF && !halted) begin
            if (!in_rec) begin
               nib = b[7:4];
               if (nib < TYPE_FIRST || nib > TYPE_LAST) begin
                  halted = 1'b1;          // rest of packet is only counted
               end else begin
                  rec_kind   = sensor_kind_type'(3'(nib - 4'd1));
                  rec_finger = b[3:2];
                  vals_done  = 6'd0;
                  held_high  = 9'd0;
                  in_rec     = 1'b1;
                  if (rec_kind == KIND_DYNAMIC) dyn_flag = 1'b1;
               end
            end else if (!held_high[8]) begin
               held_high = {1'b1, b};
            end else begin
               r = '0;
               r.result_kind  = RES_VALUE;
               r.sensor_kind  = rec_kind;
               r.finger_index = rec_finger;
               r.value_index  = vals_done;
               r.sample_value = {held_high[7:0], b};
               batch.push_back(r);
               held_high = 9'd0;
               vals_done = vals_done + 6'd1;
               if (int'(vals_done) >= int'(values_per_record(rec_kind))) begin
                  in_rec    = 1'b0;
                  vals_done = 6'd0;
               end
            end
         end
         frame_pos = frame_pos + 9'd1;
         if (frame_pos >= {1'b0, pay_len} + HDR_BYTES) begin
            r = '0;
            r.result_kind  = RES_END;
            r.dynamic_seen = dyn_flag;
            batch.push_back(r);
            frame_pos = POS_HUNT;
            clear_packet_state();
         end
      end
      if (batch.size() > 0) begin
         r = batch[batch.size() - 1];
         r.last_of_run = 1'b1;
         batch[batch.size() - 1] = r;
      end
      foreach (batch[i]) expected_q.push_back(batch[i]);
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] got_v);
      if (exp_v !== got_v) begin
         $error("result %0d: %s expected %0h, got %0h", results_seen, name, exp_v, got_v);
         error_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------
   task automatic add_record(input int kind_no, input bit truncate);
      int nbytes;
      nbytes = 2 * values_per_record(sensor_kind_type'(kind_no));
      if (truncate) nbytes = $urandom_range(nbytes - 1);
      payload_q.push_back({4'(kind_no + 1), 4'($urandom_range(15))});
      repeat (nbytes) payload_q.push_back(8'($urandom_range(255)));
   endtask

   // Frame payload_q with the given length field. Missing bytes are random;
   // surplus bytes follow the packet and land in the hunt state.
   task automatic send_packet(input logic [7:0] len, input bit drain);
      tx_byte_type t;
      t.wait_drain = drain;
      t.data = SYNC_BYTE;
      tx_bytes_q.push_back(t);
      t.wait_drain = 1'b0;
      t.data = 8'($urandom_range(255));
      tx_bytes_q.push_back(t);
      t.data = 8'($urandom_range(255));
      tx_bytes_q.push_back(t);
      t.data = len;
      tx_bytes_q.push_back(t);
      for (int i = 0; i < int'(len) || i < payload_q.size(); i++) begin
         t.data = (i < payload_q.size()) ? payload_q[i] : 8'($urandom_range(255));
         tx_bytes_q.push_back(t);
      end
      payload_q.delete();
      packets_made++;
   endtask

   task automatic add_random_traffic();
      int pick;
      int kpick;
      int nrec;
      int len;
      int nib_pick;
      tx_byte_type t;
      pick = $urandom_range(99);
      if (pick < 72) begin
         // packet of one to four records; a record may be cut short and the length may be off
         nrec = $urandom_range(1, 4);
         repeat (nrec) begin
            kpick = $urandom_range(99);
            add_record(kpick < 8 ? 0 : kpick < 30 ? 1 : kpick < 50 ? 2 :
                       kpick < 65 ? 3 : kpick < 80 ? 4 : 5,
                       $urandom_range(99) < 12);
         end
         if ($urandom_range(99) < 10) begin
            // unknown type header, then a few bytes that must be ignored
            nib_pick = $urandom_range(9);
            payload_q.push_back({4'(nib_pick == 0 ? 0 : nib_pick + 6),
                                 4'($urandom_range(15))});
            repeat ($urandom_range(4)) payload_q.push_back(8'($urandom_range(255)));
         end
         len = payload_q.size();
         if ($urandom_range(99) < 20) len = len + $urandom_range(6) - 3;
         if (len < 0) len = 0;
         if (len > 255) len = 255;
         send_packet(8'(len), $urandom_range(29) == 0);
      end else if (pick < 87) begin
         // short packet of random bytes
         repeat ($urandom_range(12)) payload_q.push_back(8'($urandom_range(255)));
         send_packet(8'(payload_q.size()), 1'b0);
      end else if (pick < 89) begin
         // long payload: parsing stops at the window limit
         add_record(0, 1'b0);
         send_packet(8'($urandom_range(61, 255)), 1'b0);
      end else begin
         // line noise between packets
         t.wait_drain = 1'b0;
         repeat ($urandom_range(1, 6)) begin
            t.data = 8'($urandom_range(255));
            tx_bytes_q.push_back(t);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Driver: one new item per falling edge once the last one was taken.
   // The sender idles at random, 31 times in 100, except for a stretch in the middle.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (tx_bytes_q.size() == 0) begin
            req_valid <= 1'b0;
         end else if (tx_bytes_q[0].wait_drain && expected_q.size() != 0) begin
            req_valid <= 1'b0;
         end else if (!(bytes_sent >= 700 && bytes_sent < 1000) &&
                      $urandom_range(99) < 31) begin
            req_valid <= 1'b0;
         end else begin
            req_valid   <= 1'b1;
            req_in_byte <= tx_bytes_q[0].data;
            tx_bytes_q.pop_front();
         end
      end
   end

   // Receiver stall, quiet over the same stretch as the sender
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !(bytes_sent >= 700 && bytes_sent < 1000) &&
                      ($urandom_range(99) < 31);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on accepted bytes, check accepted results
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_byte(req_in_byte);
            bytes_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result %0d arrived with nothing expected", results_seen);
               error_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("result_kind", want.result_kind, rsp_result_kind);
               check_field("sensor_kind", want.sensor_kind, rsp_sensor_kind);
               check_field("finger_index", want.finger_index, rsp_finger_index);
               check_field("value_index", want.value_index, rsp_value_index);
               check_field("sample_value", want.sample_value, rsp_sample_value);
               check_field("dynamic_seen", want.dynamic_seen, rsp_dynamic_seen);
               check_field("last_of_run", want.last_of_run, rsp_last_of_run);
            end
            if (rsp_result_kind == RES_END) end_markers++;
            results_seen++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      // zero length: marker right after the length byte
      send_packet(8'd0, 1'b0);
      // temperature value on the last byte: value then end marker
      payload_q = '{8'h60, 8'h00, 8'h01};
      send_packet(8'd3, 1'b0);
      // dynamic record with its single value, which completes the record
      payload_q = '{8'h2C, 8'hFF, 8'hFF};
      send_packet(8'd3, 1'b0);
      // unknown type halts the packet
      payload_q = '{8'h70};
      send_packet(8'd1, 1'b0);
      // static header alone: end marker without the dynamic flag
      payload_q = '{8'h18};
      send_packet(8'd1, 1'b0);
      // random part; the first packet waits for the directed results
      payload_q = '{8'h1C, 8'h00, 8'h00};
      send_packet(8'd3, 1'b1);
      while (tx_bytes_q.size() < 1850) add_random_traffic();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (tx_bytes_q.size() != 0 || req_valid) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d bytes in %0d framed packets plus noise.", bytes_sent, packets_made);
      $display("Checked %0d results, %0d of them end markers.", results_seen, end_markers);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Timeout: %0d results still expected", expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* filelist.f */
rtl/spdp_pkg.sv
rtl/sensor_packet_deframe_parser_core.sv
sim/tb_top.sv
